// File: hdl/selective_repeat_sender_window_macros.svh
// Assertion macros shared by the checker of the selective-repeat sender window.
// The checker that uses them provides clk and rst_n.
`ifndef SELECTIVE_REPEAT_SENDER_WINDOW_MACROS_SVH
`define SELECTIVE_REPEAT_SENDER_WINDOW_MACROS_SVH

// Clocked property that is switched off while reset is asserted.
`define SRSW_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that is also checked while reset is asserted.
`define SRSW_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/srsw_pkg.sv
// ----------------------------------------------------------------------------
// srsw_pkg: shared definitions of the selective-repeat sender window
// Field widths, request and result codes, sequencer states and the table that
// maps a sequence number onto its frame slot.
// ----------------------------------------------------------------------------
`default_nettype none

package srsw_pkg;

    localparam int WINDOW_MAX = 8;
    localparam int AGE_BITS   = 16;

    localparam int SEQ_W    = 8;
    localparam int SEQ_NUM  = 1 << SEQ_W;
    localparam int MODE_W   = 2;
    localparam int KIND_W   = 3;
    localparam int WIN_W    = 4;
    localparam int TMO_W    = 16;
    localparam int CFG_A_W  = 2;
    localparam int CFG_D_W  = 16;
    localparam int SLOT_W   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CLAMP_W  = 33;

    localparam logic [SEQ_W-1:0]    WIN_MAX_SEQ = SEQ_W'(WINDOW_MAX);
    localparam logic [AGE_BITS-1:0] AGE_MAX     = '1;

    // Request modes.
    localparam logic [MODE_W-1:0] MODE_SEND = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ACK  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TICK = 2'd2;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_SENT    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FULL    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_ACKED   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_IGNORED = 3'd3;
    localparam logic [KIND_W-1:0] KIND_RETX    = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_A_W-1:0] CFG_WINDOW_SIZE   = 2'd0;
    localparam logic [CFG_A_W-1:0] CFG_TIMEOUT_TICKS = 2'd1;

    typedef logic [AGE_BITS-1:0] age_t;
    typedef logic [SLOT_W-1:0]   slot_t;
    typedef slot_t               slot_tab_t [SEQ_NUM];

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SLIDE,
        ST_SCAN,
        ST_EMIT
    } srsw_state_t;

    // Built at elaboration: slot of every sequence number.
    function automatic slot_tab_t build_slot_table();
        slot_tab_t tab;
        for (int i = 0; i < SEQ_NUM; i++)
        begin
            tab[i] = SLOT_W'(i % WINDOW_MAX);
        end
        return tab;
    endfunction

    localparam slot_tab_t SLOT_OF = build_slot_table();

    // Timeout limited to the largest age a slot can hold.
    function automatic age_t clamp_limit(input logic [TMO_W-1:0] ticks);
        logic [CLAMP_W-1:0] wide;
        wide = CLAMP_W'(ticks);
        if (wide > CLAMP_W'(AGE_MAX))
        begin
            return AGE_MAX;
        end
        return AGE_BITS'(wide);
    endfunction

endpackage

`default_nettype wire

// File: hdl/srsw_if.sv
// ----------------------------------------------------------------------------
// srsw_if: channel interfaces of the selective-repeat sender window
// Request, result and configuration channels, each with valid and ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface srsw_req_if;
    logic                           valid;
    logic                           ready;
    logic [srsw_pkg::MODE_W-1:0]    mode;
    logic [srsw_pkg::SEQ_W-1:0]     ack_seq;

    modport source (output valid, output mode, output ack_seq, input ready);
    modport sink   (input valid, input mode, input ack_seq, output ready);
endinterface

interface srsw_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [srsw_pkg::KIND_W-1:0]    kind;
    logic [srsw_pkg::SEQ_W-1:0]     seq;
    logic [srsw_pkg::SEQ_W-1:0]     window_base;
    logic                           last;

    modport source (output valid, output kind, output seq, output window_base,
                    output last, input ready);
    modport sink   (input valid, input kind, input seq, input window_base,
                    input last, output ready);
endinterface

interface srsw_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [srsw_pkg::CFG_A_W-1:0]   addr;
    logic [srsw_pkg::CFG_D_W-1:0]   data;

    modport source (output valid, output addr, output data, input ready);
    modport sink   (input valid, input addr, input data, output ready);
endinterface

`default_nettype wire

// File: hdl/selective_repeat_sender_window.sv
// ----------------------------------------------------------------------------
// selective_repeat_sender_window: sender window of a selective-repeat ARQ link
// Hands out sequence numbers, records acknowledgments and asks for
// retransmission of frames whose age reaches the timeout.
// ----------------------------------------------------------------------------
// A request is taken only while the sequencer is idle. A send request goes
// to the emit state, which hands over its result. An ACK passes through the
// slide state, which moves the window base past every acknowledged frame at
// its head, then the emit state. A tick with frames outstanding scans each of
// them, at most WINDOW_MAX, since a single age incrementer and timeout
// comparator visits the slots in order from the window base; the emit state
// hands over its final retransmit, if any. Every result passes through one
// output register, so a result that waits to be taken holds the sequencer
// only when a new one is ready behind it; the next request is taken while the
// final result still waits. Control and window state, including every slot's
// acked flag and age, is cleared by reset at once; no clearing pass follows.
`default_nettype none

module selective_repeat_sender_window (
    input  wire         clk,
    input  wire         rst_n,
    srsw_req_if.sink    request,
    srsw_rsp_if.source  result,
    srsw_cfg_if.sink    cfg
);

    localparam int W     = srsw_pkg::WINDOW_MAX;
    localparam int SEQ_W = srsw_pkg::SEQ_W;

    // Sequencer state.
    srsw_pkg::srsw_state_t state_reg, state_next;

    // Configuration registers.
    logic [srsw_pkg::WIN_W-1:0] window_size_reg;
    logic [srsw_pkg::TMO_W-1:0] timeout_reg;

    // Window state.
    logic [SEQ_W-1:0]   base_reg, base_next;
    logic [SEQ_W-1:0]   next_seq_reg, next_seq_next;
    logic [W-1:0]       acked_reg, acked_next;
    srsw_pkg::age_t     age_reg [W];
    srsw_pkg::age_t     age_next [W];

    // Tick scan control.
    srsw_pkg::slot_t    idx_reg, idx_next;
    srsw_pkg::slot_t    last_idx_reg, last_idx_next;
    srsw_pkg::age_t     limit_reg, limit_next;

    // Result held back until it is known whether it is the final one.
    logic                           pend_valid_reg, pend_valid_next;
    logic [srsw_pkg::KIND_W-1:0]    pend_kind_reg, pend_kind_next;
    logic [SEQ_W-1:0]               pend_seq_reg, pend_seq_next;

    // Output register.
    logic                           out_valid_reg, out_valid_next;
    logic [srsw_pkg::KIND_W-1:0]    out_kind_reg, out_kind_next;
    logic [SEQ_W-1:0]               out_seq_reg, out_seq_next;
    logic [SEQ_W-1:0]               out_base_reg, out_base_next;
    logic                           out_last_reg, out_last_next;

    logic               req_xfer;
    logic               out_free;
    logic [SEQ_W-1:0]   outstanding;
    logic [SEQ_W-1:0]   win_ext;
    logic [SEQ_W-1:0]   eff_window;
    logic               window_full;
    logic               ack_in_window;
    srsw_pkg::slot_t    next_slot;
    srsw_pkg::slot_t    ack_slot;
    srsw_pkg::slot_t    base_slot;
    logic               slide_more;
    logic [SEQ_W-1:0]   scan_seq;
    srsw_pkg::slot_t    scan_slot;
    srsw_pkg::age_t     scan_age;
    srsw_pkg::age_t     age_inc;
    logic               scan_due;
    logic               scan_stall;
    logic               scan_done;

    assign request.ready = (state_reg == srsw_pkg::ST_IDLE);
    assign cfg.ready     = 1'b1;

    assign result.valid       = out_valid_reg;
    assign result.kind        = out_kind_reg;
    assign result.seq         = out_seq_reg;
    assign result.window_base = out_base_reg;
    assign result.last        = out_last_reg;

    assign req_xfer = request.valid && request.ready;
    // The output register can take a new result in this cycle.
    assign out_free = !out_valid_reg || result.ready;

    // Window occupancy. It never exceeds WINDOW_MAX, so slots never alias.
    assign outstanding = next_seq_reg - base_reg;
    assign win_ext     = SEQ_W'(window_size_reg);
    always_comb
    begin
        if (win_ext == '0)
        begin
            eff_window = SEQ_W'(1);
        end
        else if (win_ext > srsw_pkg::WIN_MAX_SEQ)
        begin
            eff_window = srsw_pkg::WIN_MAX_SEQ;
        end
        else
        begin
            eff_window = win_ext;
        end
    end
    assign window_full   = (outstanding >= eff_window);
    assign ack_in_window = ((request.ack_seq - base_reg) < outstanding);

    assign next_slot  = srsw_pkg::SLOT_OF[next_seq_reg];
    assign ack_slot   = srsw_pkg::SLOT_OF[request.ack_seq];
    assign base_slot  = srsw_pkg::SLOT_OF[base_reg];
    assign slide_more = (base_reg != next_seq_reg) && acked_reg[base_slot];

    // The shared aging unit: one slot per cycle while the scan is not stalled,
    // saturating increment and a compare against the timeout.
    assign scan_seq   = base_reg + SEQ_W'(idx_reg);
    assign scan_slot  = srsw_pkg::SLOT_OF[scan_seq];
    assign scan_age   = age_reg[scan_slot];
    assign age_inc    = (scan_age == srsw_pkg::AGE_MAX) ? scan_age
                                                        : scan_age + 1'b1;
    assign scan_due   = !acked_reg[scan_slot] && (age_inc >= limit_reg);
    // A second due frame needs the held result moved out first.
    assign scan_stall = scan_due && pend_valid_reg && !out_free;
    assign scan_done  = (idx_reg == last_idx_reg);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            srsw_pkg::ST_IDLE:
            begin
                if (req_xfer)
                begin
                    if (request.mode == srsw_pkg::MODE_SEND)
                    begin
                        state_next = srsw_pkg::ST_EMIT;
                    end
                    else if (request.mode == srsw_pkg::MODE_ACK)
                    begin
                        state_next = srsw_pkg::ST_SLIDE;
                    end
                    else if (request.mode == srsw_pkg::MODE_TICK && outstanding != '0)
                    begin
                        state_next = srsw_pkg::ST_SCAN;
                    end
                end
            end
            srsw_pkg::ST_SLIDE:
            begin
                if (!slide_more)
                begin
                    state_next = srsw_pkg::ST_EMIT;
                end
            end
            srsw_pkg::ST_SCAN:
            begin
                if (!scan_stall && scan_done)
                begin
                    state_next = (pend_valid_reg || scan_due) ? srsw_pkg::ST_EMIT
                                                              : srsw_pkg::ST_IDLE;
                end
            end
            srsw_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = srsw_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = srsw_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and result outputs.
    always_comb
    begin
        base_next       = base_reg;
        next_seq_next   = next_seq_reg;
        acked_next      = acked_reg;
        age_next        = age_reg;
        idx_next        = idx_reg;
        last_idx_next   = last_idx_reg;
        limit_next      = limit_reg;
        pend_valid_next = pend_valid_reg;
        pend_kind_next  = pend_kind_reg;
        pend_seq_next   = pend_seq_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        out_kind_next   = out_kind_reg;
        out_seq_next    = out_seq_reg;
        out_base_next   = out_base_reg;
        out_last_next   = out_last_reg;

        unique case (state_reg)
            srsw_pkg::ST_IDLE:
            begin
                if (req_xfer)
                begin
                    if (request.mode == srsw_pkg::MODE_SEND)
                    begin
                        pend_valid_next = 1'b1;
                        pend_seq_next   = next_seq_reg;
                        if (window_full)
                        begin
                            pend_kind_next = srsw_pkg::KIND_FULL;
                        end
                        else
                        begin
                            pend_kind_next        = srsw_pkg::KIND_SENT;
                            acked_next[next_slot] = 1'b0;
                            age_next[next_slot]   = '0;
                            next_seq_next         = next_seq_reg + 1'b1;
                        end
                    end
                    else if (request.mode == srsw_pkg::MODE_ACK)
                    begin
                        pend_valid_next = 1'b1;
                        pend_seq_next   = request.ack_seq;
                        if (ack_in_window)
                        begin
                            pend_kind_next       = srsw_pkg::KIND_ACKED;
                            acked_next[ack_slot] = 1'b1;
                        end
                        else
                        begin
                            pend_kind_next = srsw_pkg::KIND_IGNORED;
                        end
                    end
                    else if (request.mode == srsw_pkg::MODE_TICK)
                    begin
                        pend_valid_next = 1'b0;
                        idx_next        = '0;
                        last_idx_next   = srsw_pkg::SLOT_W'(outstanding - 1'b1);
                        limit_next      = srsw_pkg::clamp_limit(timeout_reg);
                    end
                end
            end
            srsw_pkg::ST_SLIDE:
            begin
                if (slide_more)
                begin
                    base_next = base_reg + 1'b1;
                end
            end
            srsw_pkg::ST_SCAN:
            begin
                if (!scan_stall)
                begin
                    idx_next = idx_reg + 1'b1;
                    if (!acked_reg[scan_slot])
                    begin
                        age_next[scan_slot] = scan_due ? '0 : age_inc;
                    end
                    if (scan_due)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_kind_next  = pend_kind_reg;
                            out_seq_next   = pend_seq_reg;
                            out_base_next  = base_reg;
                            out_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_kind_next  = srsw_pkg::KIND_RETX;
                        pend_seq_next   = scan_seq;
                    end
                end
            end
            srsw_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = pend_kind_reg;
                    out_seq_next    = pend_seq_reg;
                    out_base_next   = base_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                end
            end
            default:
            begin
                pend_valid_next = 1'b0;
            end
        endcase
    end

    // Control and window state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= srsw_pkg::ST_IDLE;
            window_size_reg <= srsw_pkg::WIN_W'(4);
            timeout_reg     <= srsw_pkg::TMO_W'(2000);
            base_reg        <= '0;
            next_seq_reg    <= '0;
            acked_reg       <= '0;
            for (int i = 0; i < W; i++)
            begin
                age_reg[i] <= '0;
            end
            pend_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            base_reg       <= base_next;
            next_seq_reg   <= next_seq_next;
            acked_reg      <= acked_next;
            age_reg        <= age_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg.addr)
                    srsw_pkg::CFG_WINDOW_SIZE:
                    begin
                        window_size_reg <= cfg.data[srsw_pkg::WIN_W-1:0];
                    end
                    srsw_pkg::CFG_TIMEOUT_TICKS:
                    begin
                        timeout_reg <= cfg.data[srsw_pkg::TMO_W-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        last_idx_reg  <= last_idx_next;
        limit_reg     <= limit_next;
        pend_kind_reg <= pend_kind_next;
        pend_seq_reg  <= pend_seq_next;
        out_kind_reg  <= out_kind_next;
        out_seq_reg   <= out_seq_next;
        out_base_reg  <= out_base_next;
        out_last_reg  <= out_last_next;
    end

endmodule

`default_nettype wire

// File: hdl/srsw_checker.sv
// ----------------------------------------------------------------------------
// srsw_checker: port-level checks of the selective-repeat sender window
// Watches the request and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "selective_repeat_sender_window_macros.svh"

module srsw_checker (
    input wire                          clk,
    input wire                          rst_n,
    input wire                          req_valid,
    input wire                          req_ready,
    input wire [srsw_pkg::MODE_W-1:0]   req_mode,
    input wire                          rsp_valid,
    input wire                          rsp_ready,
    input wire [srsw_pkg::KIND_W-1:0]   rsp_kind,
    input wire [srsw_pkg::SEQ_W-1:0]    rsp_seq,
    input wire [srsw_pkg::SEQ_W-1:0]    rsp_window_base,
    input wire                          rsp_last
);

    logic                                           rsp_wait;
    logic [srsw_pkg::KIND_W+2*srsw_pkg::SEQ_W:0]    rsp_payload;
    logic                                           rsp_single;
    logic                                           req_single_xfer;

    assign rsp_wait    = rsp_valid && !rsp_ready;
    assign rsp_payload = {rsp_kind, rsp_seq, rsp_window_base, rsp_last};
    assign rsp_single  = (rsp_kind == srsw_pkg::KIND_SENT)
                      || (rsp_kind == srsw_pkg::KIND_FULL)
                      || (rsp_kind == srsw_pkg::KIND_ACKED)
                      || (rsp_kind == srsw_pkg::KIND_IGNORED);
    assign req_single_xfer = req_valid && req_ready
                          && (req_mode == srsw_pkg::MODE_SEND
                              || req_mode == srsw_pkg::MODE_ACK);

    // A stalled result keeps its contents.
    `SRSW_ASSERT(a_rsp_hold, rsp_wait |=> rsp_valid && $stable(rsp_payload), "stalled result moved")

    // Send and ACK requests give exactly one result, so it is the final one.
    `SRSW_ASSERT(a_single_last, rsp_valid && rsp_single |-> rsp_last, "single result without last")

    // The sequencer is busy right after taking a send or ACK request.
    `SRSW_ASSERT(a_busy_after_req, req_single_xfer |=> !req_ready, "request taken while busy")

    // No result is offered while reset is asserted.
    `SRSW_ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> !rsp_valid, "result valid during reset")

endmodule

bind selective_repeat_sender_window srsw_checker u_srsw_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (request.valid),
    .req_ready       (request.ready),
    .req_mode        (request.mode),
    .rsp_valid       (result.valid),
    .rsp_ready       (result.ready),
    .rsp_kind        (result.kind),
    .rsp_seq         (result.seq),
    .rsp_window_base (result.window_base),
    .rsp_last        (result.last)
);

`default_nettype wire
